[rtl/core/tfd_pkg.sv]
package tfd_pkg;

    localparam int HEADER_BYTES_DEF = 5;

    localparam int OFFSET_W = 21;
    localparam int COUNT_W  = 16;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    // byte classes
    localparam logic [1:0] CLS_HEADER  = 2'd0;
    localparam logic [1:0] CLS_PAYLOAD = 2'd1;
    localparam logic [1:0] CLS_BODY    = 2'd2;
    localparam logic [1:0] CLS_FLAG    = 2'd3;

    // frame kinds held while inside a frame
    localparam logic [1:0] FRM_NONE = 2'd0;
    localparam logic [1:0] FRM_DATA = 2'd1;
    localparam logic [1:0] FRM_CTRL = 2'd2;

    // end-of-frame status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_UNCHKD   = 2'd2;

    // register indexes
    localparam logic [2:0] REG_DATA_FLAG   = 3'd0;
    localparam logic [2:0] REG_CTRL_FLAG   = 3'd1;
    localparam logic [2:0] REG_ODD_CODE    = 3'd2;
    localparam logic [2:0] REG_EVEN_CODE   = 3'd3;
    localparam logic [2:0] REG_UCHAR_TYPE  = 3'd4;
    localparam logic [2:0] REG_SINGLE_TYPE = 3'd5;
    localparam logic [2:0] REG_DOUBLE_TYPE = 3'd6;

    typedef struct packed {
        logic [7:0] data_flag_code;
        logic [7:0] control_flag_code;
        logic [7:0] odd_code;
        logic [7:0] even_code;
        logic [7:0] uchar_type_code;
        logic [7:0] single_type_code;
        logic [7:0] double_type_code;
    } cfg_t;

    typedef struct packed {
        logic [7:0]          byte_value;
        logic [1:0]          byte_class;
        logic [OFFSET_W-1:0] frame_offset;
        logic [7:0]          frame_type;
        logic [COUNT_W-1:0]  element_count;
        logic                last;
        logic [1:0]          status;
    } result_t;

endpackage

[rtl/core/tfd_parse.sv]
module tfd_parse
    import tfd_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  logic [7:0] in_byte,
    input  cfg_t       cfg,
    output result_t    res
);

    localparam int HPW = $clog2(HEADER_BYTES + 1);
    localparam logic [HPW-1:0] POS_FLAG   = HPW'(0);
    localparam logic [HPW-1:0] POS_TYPE   = HPW'(1);
    localparam logic [HPW-1:0] POS_PARITY = HPW'(2);
    localparam logic [HPW-1:0] POS_CNT_HI = HPW'(3);
    localparam logic [HPW-1:0] POS_LAST   = HPW'(HEADER_BYTES - 1);
    localparam logic [HPW-1:0] POS_BODY   = HPW'(HEADER_BYTES);

    logic [HPW-1:0]      hp_reg, hp_next;
    logic [1:0]          frm_reg, frm_next;
    logic [7:0]          type_reg, type_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [OFFSET_W-1:0] rem_reg, rem_next;
    logic [OFFSET_W-1:0] off_reg, off_next;
    logic                par_reg, par_next;
    logic [7:0]          rpc_reg, rpc_next;

    logic                finish;
    logic                type_chk;
    logic [7:0]          got_code;
    logic [OFFSET_W-1:0] body_len;

    always_comb begin
        hp_next    = hp_reg;
        frm_next   = frm_reg;
        type_next  = type_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        off_next   = off_reg;
        par_next   = par_reg;
        rpc_next   = rpc_reg;
        finish     = 1'b0;
        body_len   = '0;

        res.byte_value    = in_byte;
        res.byte_class    = CLS_HEADER;
        res.frame_offset  = '0;
        res.frame_type    = '0;
        res.element_count = '0;
        res.last          = 1'b0;
        res.status        = ST_OK;

        if (hp_reg == POS_FLAG || hp_reg > POS_BODY) begin
            off_next   = OFFSET_W'(1);
            type_next  = '0;
            count_next = '0;
            rem_next   = '0;
            par_next   = 1'b0;
            rpc_next   = '0;
            // data flag wins when both codes are equal
            if (in_byte == cfg.data_flag_code) begin
                frm_next = FRM_DATA;
                hp_next  = POS_TYPE;
            end else if (in_byte == cfg.control_flag_code) begin
                frm_next = FRM_CTRL;
                hp_next  = POS_TYPE;
            end else begin
                frm_next       = FRM_NONE;
                hp_next        = POS_FLAG;
                res.byte_class = CLS_FLAG;
                res.last       = 1'b1;
                res.status     = ST_UNCHKD;
            end
        end else if (hp_reg < POS_BODY) begin
            res.frame_offset = off_reg;
            off_next         = off_reg + OFFSET_W'(1);
            if (frm_reg == FRM_DATA) begin
                if (hp_reg == POS_TYPE) begin
                    type_next = in_byte;
                end else if (hp_reg == POS_PARITY) begin
                    rpc_next = in_byte;
                end else if (hp_reg == POS_CNT_HI) begin
                    count_next = {in_byte, 8'h00};
                end else if (hp_reg == POS_LAST) begin
                    count_next = count_reg | COUNT_W'(in_byte);
                end
            end else if (hp_reg == POS_LAST) begin
                count_next = COUNT_W'(in_byte);
            end
            hp_next = hp_reg + HPW'(1);
            if (hp_reg == POS_LAST) begin
                if (frm_reg == FRM_DATA) begin
                    body_len = OFFSET_W'(count_next) * OFFSET_W'(type_next[7:3]);
                end else begin
                    body_len = OFFSET_W'(count_next);
                end
                rem_next = body_len;
                finish   = (body_len == '0);
            end
        end else begin
            res.byte_class   = (frm_reg == FRM_DATA) ? CLS_PAYLOAD : CLS_BODY;
            res.frame_offset = off_reg;
            off_next         = off_reg + OFFSET_W'(1);
            par_next         = par_reg ^ in_byte[0];
            if (rem_reg != '0) begin
                rem_next = rem_reg - OFFSET_W'(1);
            end
            finish = (rem_reg <= OFFSET_W'(1));
        end

        if (frm_next == FRM_DATA) begin
            res.frame_type = type_next;
        end
        res.element_count = count_next;

        type_chk = (type_next == cfg.uchar_type_code) ||
                   (type_next == cfg.single_type_code) ||
                   (type_next == cfg.double_type_code);
        got_code = par_next ? cfg.odd_code : cfg.even_code;

        if (finish) begin
            res.last = 1'b1;
            if (frm_next != FRM_DATA || !type_chk) begin
                res.status = ST_UNCHKD;
            end else if (got_code == rpc_next) begin
                res.status = ST_OK;
            end else begin
                res.status = ST_MISMATCH;
            end
            hp_next  = POS_FLAG;
            frm_next = FRM_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hp_reg    <= POS_FLAG;
            frm_reg   <= FRM_NONE;
            type_reg  <= '0;
            count_reg <= '0;
            rem_reg   <= '0;
            off_reg   <= '0;
            par_reg   <= 1'b0;
            rpc_reg   <= '0;
        end else if (fire) begin
            hp_reg    <= hp_next;
            frm_reg   <= frm_next;
            type_reg  <= type_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            off_reg   <= off_next;
            par_reg   <= par_next;
            rpc_reg   <= rpc_next;
        end
    end

endmodule

[rtl/core/typed_frame_deframer_parity_check.sv]
// Splits a received byte stream into data, control and one-byte frames and
// echoes every byte with its class (tuser), its offset in the frame, the data
// type code, the element count or body length, and a last mark (tlast); the
// last beat of a frame carries the payload parity status. One byte is taken
// per clock, sustained while the sink accepts result beats; the frame state
// updates as each byte moves from the input register through the parser into
// the output register. Flag, parity and type codes are set over the APB port
// and must only be changed while the stream is idle.
module typed_frame_deframer_parity_check
    import tfd_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // in_byte

    output logic              m_tvalid,
    input  logic              m_tready,
    // byte_value [7:0], frame_offset [28:8], frame_type [36:29],
    // element_count [52:37], status [54:53], zero [55]
    output logic [55:0]       m_tdata,
    output logic [1:0]        m_tuser,   // byte_class
    output logic              m_tlast,   // last

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    res;
    logic       advance;
    logic       fire;
    logic       wr_en;
    logic [2:0] reg_idx;

    // configuration
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.data_flag_code    <= 8'd1;
            cfg_reg.control_flag_code <= 8'd2;
            cfg_reg.odd_code          <= 8'd1;
            cfg_reg.even_code         <= 8'd0;
            cfg_reg.uchar_type_code   <= 8'd8;
            cfg_reg.single_type_code  <= 8'd32;
            cfg_reg.double_type_code  <= 8'd64;
        end else if (wr_en) begin
            case (reg_idx)
                REG_DATA_FLAG:   cfg_reg.data_flag_code    <= pwdata[7:0];
                REG_CTRL_FLAG:   cfg_reg.control_flag_code <= pwdata[7:0];
                REG_ODD_CODE:    cfg_reg.odd_code          <= pwdata[7:0];
                REG_EVEN_CODE:   cfg_reg.even_code         <= pwdata[7:0];
                REG_UCHAR_TYPE:  cfg_reg.uchar_type_code   <= pwdata[7:0];
                REG_SINGLE_TYPE: cfg_reg.single_type_code  <= pwdata[7:0];
                REG_DOUBLE_TYPE: cfg_reg.double_type_code  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DATA_FLAG:   prdata = APB_DW'(cfg_reg.data_flag_code);
            REG_CTRL_FLAG:   prdata = APB_DW'(cfg_reg.control_flag_code);
            REG_ODD_CODE:    prdata = APB_DW'(cfg_reg.odd_code);
            REG_EVEN_CODE:   prdata = APB_DW'(cfg_reg.even_code);
            REG_UCHAR_TYPE:  prdata = APB_DW'(cfg_reg.uchar_type_code);
            REG_SINGLE_TYPE: prdata = APB_DW'(cfg_reg.single_type_code);
            REG_DOUBLE_TYPE: prdata = APB_DW'(cfg_reg.double_type_code);
            default:         prdata = '0;
        endcase
    end

    // pipeline: input register -> parser -> output register
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    tfd_parse #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .in_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // hold the result beat while the sink stalls
    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.byte_class;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {1'b0, out_reg.status, out_reg.element_count, out_reg.frame_type,
                       out_reg.frame_offset, out_reg.byte_value};

endmodule
